// File: sv/rsi_pkg.sv
// Shared types and constants for the ray/sphere intersection pipeline.
// No dependencies; used by rsi_mul and ray_sphere_intersect.
package rsi_pkg;

  // bits of the multiplier operand consumed by one multiplier cell
  localparam int unsigned MUL_DIGIT = 16;

  // configuration register map, in address order
  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_RADIUS
  } rsi_reg_e;

  // per-ray result qualifiers carried beside the datapath
  typedef struct packed {
    logic hit;
    logic plus_ok;
    logic minus_ok;
  } rsi_root_flags_t;

  // sign and zero tests on the quadratic coefficients
  typedef struct packed {
    logic a_zero;
    logic b_le0;
    logic c_le0;
    logic c_ge0;
  } rsi_coef_flags_t;

endpackage

// File: sv/rsi_mul.sv
// Wide unsigned multiplier built as a chain of digit cells.
// Each cell adds the partial product of one MUL_DIGIT-bit digit; depends on rsi_pkg.
module rsi_mul #(
  parameter int unsigned AW = 67,
  parameter int unsigned BW = 67,
  parameter int unsigned TW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [TW-1:0]    tag_i,
  output logic             vld_o,
  output logic [AW+BW-1:0] p_o,
  output logic [TW-1:0]    tag_o
);

  localparam int unsigned DIG = rsi_pkg::MUL_DIGIT;
  localparam int unsigned NC  = (BW + DIG - 1) / DIG;
  localparam int unsigned BPW = NC * DIG;
  localparam int unsigned PW  = AW + BW;

  logic          vld_q [NC];
  logic [AW-1:0]  a_q  [NC];
  logic [BPW-1:0] b_q  [NC];
  logic [PW-1:0]  acc_q[NC];
  logic [TW-1:0]  tag_q[NC];

  for (genvar k = 0; k < NC; k++) begin : g_cell
    logic           vld_in;
    logic [AW-1:0]  a_in;
    logic [BPW-1:0] b_in;
    logic [PW-1:0]  acc_in;
    logic [TW-1:0]  tag_in;
    logic [AW+DIG-1:0] pp;

    if (k == 0) begin : g_head
      assign vld_in = vld_i;
      assign a_in   = a_i;
      assign b_in   = BPW'(b_i);
      assign acc_in = '0;
      assign tag_in = tag_i;
    end else begin : g_link
      assign vld_in = vld_q[k-1];
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign acc_in = acc_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // partial product of the full multiplicand and the low digit
    assign pp = (AW+DIG)'(a_in) * (AW+DIG)'(b_in[DIG-1:0]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    // accumulate at this digit's weight, advance the multiplier digit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]   <= a_in;
        b_q[k]   <= b_in >> DIG;
        acc_q[k] <= acc_in + (PW'(pp) << (DIG * k));
        tag_q[k] <= tag_in;
      end
    end
  end

  assign vld_o = vld_q[NC-1];
  assign p_o   = acc_q[NC-1];
  assign tag_o = tag_q[NC-1];

endmodule

// File: sv/rsi_sqrt.sv
// Integer square root as a chain of cells, one root bit per cell.
// Standalone; instantiated by ray_sphere_intersect.
module rsi_sqrt #(
  parameter int unsigned IW = 132,
  parameter int unsigned TW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [IW-1:0]     x_i,
  input  logic [TW-1:0]     tag_i,
  output logic              vld_o,
  output logic [IW/2-1:0]   root_o,
  output logic [TW-1:0]     tag_o
);

  localparam int unsigned NC   = IW / 2;
  localparam int unsigned RW   = NC;
  localparam int unsigned REMW = RW + 3;

  logic            vld_q [NC];
  logic [IW-1:0]   x_q   [NC];
  logic [REMW-1:0] rem_q [NC];
  logic [RW-1:0]   root_q[NC];
  logic [TW-1:0]   tag_q [NC];

  for (genvar k = 0; k < NC; k++) begin : g_cell
    logic            vld_in;
    logic [IW-1:0]   x_in;
    logic [REMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [TW-1:0]   tag_in;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            take;

    if (k == 0) begin : g_head
      assign vld_in  = vld_i;
      assign x_in    = x_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_link
      assign vld_in  = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    // bring down two radicand bits and try root*4+1
    assign rem_sh = {rem_in[REMW-3:0], x_in[IW-1 -: 2]};
    assign trial  = REMW'({root_in, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_in << 2;
        rem_q[k]  <= take ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[RW-2:0], take};
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign vld_o  = vld_q[NC-1];
  assign root_o = root_q[NC-1];
  assign tag_o  = tag_q[NC-1];

endmodule

// File: sv/rsi_div.sv
// Restoring divider as a chain of cells giving floor(num * 2^FB / den).
// One quotient bit per cell plus an entry stage that flags overflow.
module rsi_div #(
  parameter int unsigned NW = 66,
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 32,
  parameter int unsigned FB = 16,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QW-1:0] q_o,
  output logic          ovf_o,
  output logic [TW-1:0] tag_o
);

  localparam int unsigned NSW = NW + FB;

  logic [NSW-1:0] num_sh;
  logic [NSW-1:0] num_top;
  logic           big;

  // quotient reaches 2^QW exactly when the upper numerator part is >= den
  assign num_sh  = NSW'(num_i) << FB;
  assign num_top = num_sh >> QW;
  assign big     = num_top >= NSW'(den_i);

  logic          vld0_q;
  logic          ovf0_q;
  logic [DW-1:0] rem0_q;
  logic [DW-1:0] den0_q;
  logic [QW-1:0] low0_q;
  logic [TW-1:0] tag0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf0_q <= big;
      rem0_q <= big ? '0 : num_top[DW-1:0];
      den0_q <= den_i;
      low0_q <= num_sh[QW-1:0];
      tag0_q <= tag_i;
    end
  end

  logic          vld_q[QW];
  logic          ovf_q[QW];
  logic [DW-1:0] rem_q[QW];
  logic [DW-1:0] den_q[QW];
  logic [QW-1:0] low_q[QW];
  logic [QW-1:0] quo_q[QW];
  logic [TW-1:0] tag_q[QW];

  for (genvar k = 0; k < QW; k++) begin : g_cell
    logic          vld_in;
    logic          ovf_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          take;

    if (k == 0) begin : g_head
      assign vld_in = vld0_q;
      assign ovf_in = ovf0_q;
      assign rem_in = rem0_q;
      assign den_in = den0_q;
      assign low_in = low0_q;
      assign quo_in = '0;
      assign tag_in = tag0_q;
    end else begin : g_link
      assign vld_in = vld_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // shift in the next numerator bit and subtract when it fits
    assign rem_sh = {rem_in, low_in[QW-1]};
    assign diff   = rem_sh - {1'b0, den_in};
    assign take   = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[k] <= ovf_in;
        rem_q[k] <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
        den_q[k] <= den_in;
        low_q[k] <= low_in << 1;
        quo_q[k] <= {quo_in[QW-2:0], take};
        tag_q[k] <= tag_in;
      end
    end
  end

  assign vld_o = vld_q[QW-1];
  assign q_o   = quo_q[QW-1];
  assign ovf_o = ovf_q[QW-1];
  assign tag_o = tag_q[QW-1];

endmodule

// File: sv/ray_sphere_intersect.sv
// Ray/sphere intersection test. One ray (origin and direction, signed fixed
// point with FRAC_BITS fraction bits, Q16.16 by default) enters per clock and
// one result leaves per clock; the whole pipeline holds while a result waits
// untaken at the output. The pipeline is 5 input/product/sum stages,
// ceil((2*COORD_WIDTH+3)/16) multiplier cells, 1 discriminant stage,
// 2*COORD_WIDTH+2 square-root cells, 1 numerator stage, an entry stage and
// COORD_WIDTH cells in each divider, and the output register. The square-root
// chain is the longest part. The user must set sphere center and radius
// through the APB port only while no ray is in flight; the block does not
// enforce this. Depends on rsi_pkg, rsi_mul, rsi_sqrt and rsi_div.
module ray_sphere_intersect #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest bits first)
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // intersects, plus_valid, plus_t, minus_valid, minus_t (lowest bits first)
  output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_axis_tdata,

  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [((COORD_WIDTH > 32) ? 3 : 2)+1:0] paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic pready
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned SL    = (CW > 32) ? 3 : 2;
  localparam int unsigned PDW   = (CW > 32) ? 64 : 32;
  localparam int unsigned OUTW  = ((2*CW+1+7)/8)*8;
  localparam int unsigned VW    = CW + 1;
  localparam int unsigned AW    = 2*CW;
  localparam int unsigned BW    = 2*CW + 2;
  localparam int unsigned CCW   = 2*CW + 3;
  localparam int unsigned MW    = 2*CW + 3;
  localparam int unsigned PW    = 2*MW;
  localparam int unsigned DW    = PW + 1;
  localparam int unsigned IW    = 4*CW + 4;
  localparam int unsigned RW    = IW / 2;
  localparam int unsigned NW    = 2*CW + 2;
  localparam int unsigned CFW   = $bits(rsi_pkg::rsi_coef_flags_t);
  localparam int unsigned RFW   = $bits(rsi_pkg::rsi_root_flags_t);
  localparam int unsigned T1W   = CFW + AW + BW;
  localparam int unsigned T2W   = RFW + AW + BW;

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] cen_q[3];
  logic [CW-2:0]        rad_q;
  rsi_pkg::rsi_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = rsi_pkg::rsi_reg_e'(paddr[SL+1:SL]);

  // write on the access cycle of a transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      rad_q    <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        rsi_pkg::REG_CENTER_X: cen_q[0] <= pwdata[CW-1:0];
        rsi_pkg::REG_CENTER_Y: cen_q[1] <= pwdata[CW-1:0];
        rsi_pkg::REG_CENTER_Z: cen_q[2] <= pwdata[CW-1:0];
        rsi_pkg::REG_RADIUS:   rad_q    <= pwdata[CW-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rsi_pkg::REG_CENTER_X: prdata = PDW'(unsigned'(cen_q[0]));
      rsi_pkg::REG_CENTER_Y: prdata = PDW'(unsigned'(cen_q[1]));
      rsi_pkg::REG_CENTER_Z: prdata = PDW'(unsigned'(cen_q[2]));
      rsi_pkg::REG_RADIUS:   prdata = PDW'(rad_q);
      default:               prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ flow control
  logic            en;
  logic            m_valid_q;
  logic [OUTW-1:0] m_data_q;

  // advance everything unless a result sits untaken at the output
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ----------------------------------------------------- stage 1: capture
  logic                 vl1_q;
  logic signed [CW-1:0] o1_q[3];
  logic signed [CW-1:0] d1_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl1_q <= 1'b0;
    end else if (en) begin
      vl1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1_q[i] <= s_axis_tdata[i*CW +: CW];
        d1_q[i] <= s_axis_tdata[(3+i)*CW +: CW];
      end
    end
  end

  // ------------------------------------------- stage 2: origin minus center
  logic                 vl2_q;
  logic signed [VW-1:0] v2_q[3];
  logic signed [CW-1:0] d2_q[3];
  logic [CW-2:0]        r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl2_q <= 1'b0;
    end else if (en) begin
      vl2_q <= vl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v2_q[i] <= VW'(o1_q[i]) - VW'(cen_q[i]);
        d2_q[i] <= d1_q[i];
      end
      r2_q <= rad_q;
    end
  end

  // ------------------------------------------------ stage 3: dot products
  logic                     vl3_q;
  logic signed [2*CW-1:0]   dd3_q[3];
  logic signed [2*CW:0]     dv3_q[3];
  logic signed [2*CW+1:0]   vv3_q[3];
  logic [2*CW-3:0]          rr3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl3_q <= 1'b0;
    end else if (en) begin
      vl3_q <= vl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd3_q[i] <= (2*CW)'(d2_q[i]) * (2*CW)'(d2_q[i]);
        dv3_q[i] <= (2*CW+1)'(d2_q[i]) * (2*CW+1)'(v2_q[i]);
        vv3_q[i] <= (2*CW+2)'(v2_q[i]) * (2*CW+2)'(v2_q[i]);
      end
      rr3_q <= (2*CW-2)'(r2_q) * (2*CW-2)'(r2_q);
    end
  end

  // ------------------------------------------------ stage 4: coefficients
  logic                  vl4_q;
  logic [AW-1:0]         a4_q;
  logic signed [BW-1:0]  b4_q;
  logic signed [CCW-1:0] c4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl4_q <= 1'b0;
    end else if (en) begin
      vl4_q <= vl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_q <= AW'(dd3_q[0]) + AW'(dd3_q[1]) + AW'(dd3_q[2]);
      b4_q <= BW'(dv3_q[0]) + BW'(dv3_q[1]) + BW'(dv3_q[2]);
      c4_q <= CCW'(vv3_q[0]) + CCW'(vv3_q[1]) + CCW'(vv3_q[2]) - CCW'(rr3_q);
    end
  end

  // -------------------------------------- stage 5: magnitudes and sign tests
  logic                     vl5_q;
  logic [MW-1:0]            am5_q;
  logic [MW-1:0]            bm5_q;
  logic [MW-1:0]            cm5_q;
  logic                     cneg5_q;
  logic [AW-1:0]            a5_q;
  logic signed [BW-1:0]     b5_q;
  rsi_pkg::rsi_coef_flags_t cf5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl5_q <= 1'b0;
    end else if (en) begin
      vl5_q <= vl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      am5_q        <= MW'(a4_q);
      bm5_q        <= b4_q[BW-1] ? MW'(-b4_q) : MW'(b4_q);
      cm5_q        <= c4_q[CCW-1] ? MW'(-c4_q) : MW'(c4_q);
      cneg5_q      <= c4_q[CCW-1];
      a5_q         <= a4_q;
      b5_q         <= b4_q;
      cf5_q.a_zero <= a4_q == '0;
      cf5_q.b_le0  <= b4_q[BW-1] || (b4_q == '0);
      cf5_q.c_le0  <= c4_q[CCW-1] || (c4_q == '0);
      cf5_q.c_ge0  <= !c4_q[CCW-1];
    end
  end

  // --------------------------------------------- multiplier chains b*b, a*c
  logic           vb2;
  logic           vac;
  logic [PW-1:0]  pb2;
  logic [PW-1:0]  pac;
  logic [T1W-1:0] tag_b2;
  logic           cneg_m;

  rsi_mul #(
    .AW (MW),
    .BW (MW),
    .TW (T1W)
  ) u_mul_bb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vl5_q),
    .a_i    (bm5_q),
    .b_i    (bm5_q),
    .tag_i  ({cf5_q, a5_q, b5_q}),
    .vld_o  (vb2),
    .p_o    (pb2),
    .tag_o  (tag_b2)
  );

  rsi_mul #(
    .AW (MW),
    .BW (MW),
    .TW (1)
  ) u_mul_ac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vl5_q),
    .a_i    (am5_q),
    .b_i    (cm5_q),
    .tag_i  (cneg5_q),
    .vld_o  (vac),
    .p_o    (pac),
    .tag_o  (cneg_m)
  );

  // ---------------------------------------------- stage 6: discriminant
  rsi_pkg::rsi_coef_flags_t cf_m;
  logic [AW-1:0]            a_m;
  logic signed [BW-1:0]     b_m;
  logic [DW-1:0]            disc;
  logic                     hit;

  assign {cf_m, a_m, b_m} = tag_b2;
  assign disc = cneg_m ? DW'(pb2) + DW'(pac) : DW'(pb2) - DW'(pac);
  assign hit  = !disc[DW-1];

  logic                     vl6_q;
  logic [IW-1:0]            x6_q;
  rsi_pkg::rsi_root_flags_t rf6_q;
  logic [AW-1:0]            a6_q;
  logic signed [BW-1:0]     b6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl6_q <= 1'b0;
    end else if (en) begin
      vl6_q <= vb2 && vac;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x6_q           <= hit ? disc[IW-1:0] : '0;
      rf6_q.hit      <= hit;
      rf6_q.plus_ok  <= hit && !cf_m.a_zero && (cf_m.b_le0 || cf_m.c_le0);
      rf6_q.minus_ok <= hit && !cf_m.a_zero && cf_m.b_le0 && cf_m.c_ge0;
      a6_q           <= a_m;
      b6_q           <= b_m;
    end
  end

  // ------------------------------------------------- square-root chain
  logic                     vsq;
  logic [RW-1:0]            root;
  logic [T2W-1:0]           tag_sq;
  rsi_pkg::rsi_root_flags_t rf_s;
  logic [AW-1:0]            a_s;
  logic signed [BW-1:0]     b_s;

  rsi_sqrt #(
    .IW (IW),
    .TW (T2W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vl6_q),
    .x_i    (x6_q),
    .tag_i  ({rf6_q, a6_q, b6_q}),
    .vld_o  (vsq),
    .root_o (root),
    .tag_o  (tag_sq)
  );

  assign {rf_s, a_s, b_s} = tag_sq;

  // --------------------------------------------- stage 7: root numerators
  logic signed [RW+1:0]     root_x;
  logic signed [RW+1:0]     b_x;
  logic signed [RW+1:0]     num_p;
  logic signed [RW+1:0]     num_m;

  assign root_x = $signed({2'b00, root});
  assign b_x    = (RW+2)'(b_s);
  assign num_p  = root_x - b_x;
  assign num_m  = -b_x - root_x;

  logic                     vl7_q;
  logic [NW-1:0]            np7_q;
  logic [NW-1:0]            nm7_q;
  logic [AW-1:0]            a7_q;
  rsi_pkg::rsi_root_flags_t rf7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl7_q <= 1'b0;
    end else if (en) begin
      vl7_q <= vsq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      np7_q <= num_p[NW-1:0];
      nm7_q <= num_m[NW-1:0];
      a7_q  <= a_s;
      rf7_q <= rf_s;
    end
  end

  // ---------------------------------------------------- divider chains
  logic          vdp;
  logic          vdm;
  logic [CW-1:0] q_p;
  logic [CW-1:0] q_m;
  logic          ovf_p;
  logic          ovf_m;
  logic [1:0]    tag_p;
  logic          minus_ok;

  rsi_div #(
    .NW (NW),
    .DW (AW),
    .QW (CW),
    .FB (FRAC_BITS),
    .TW (2)
  ) u_div_plus (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vl7_q),
    .num_i  (np7_q),
    .den_i  (a7_q),
    .tag_i  ({rf7_q.hit, rf7_q.plus_ok}),
    .vld_o  (vdp),
    .q_o    (q_p),
    .ovf_o  (ovf_p),
    .tag_o  (tag_p)
  );

  rsi_div #(
    .NW (NW),
    .DW (AW),
    .QW (CW),
    .FB (FRAC_BITS),
    .TW (1)
  ) u_div_minus (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vl7_q),
    .num_i  (nm7_q),
    .den_i  (a7_q),
    .tag_i  (rf7_q.minus_ok),
    .vld_o  (vdm),
    .q_o    (q_m),
    .ovf_o  (ovf_m),
    .tag_o  (minus_ok)
  );

  // ------------------------------------------- saturate and format result
  logic [CW-2:0]   t_p;
  logic [CW-2:0]   t_m;
  logic [OUTW-1:0] out_d;

  assign t_p = !tag_p[0] ? '0 :
               (ovf_p || q_p[CW-1] || (&q_p[CW-2:0])) ? '1 : q_p[CW-2:0];
  assign t_m = !minus_ok ? '0 :
               (ovf_m || q_m[CW-1] || (&q_m[CW-2:0])) ? '1 : q_m[CW-2:0];
  assign out_d = OUTW'({t_m, minus_ok, t_p, tag_p[0], tag_p[1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= vdp && vdm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= out_d;
    end
  end

endmodule
